// File: rtl/core/nacc_pkg.sv
// Package for the nibble accumulator ALU core.
// Holds operation codes, widths and the architectural state struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nacc_pkg;

	localparam int unsigned NIB_W  = 4;
	localparam int unsigned BANK_W = 3;
	localparam int unsigned CMD_W  = 5;
	localparam int unsigned NREGS  = 16;
	localparam int unsigned RIDX_W = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_LD   = 5'd0,
		CMD_XCH  = 5'd1,
		CMD_ADD  = 5'd2,
		CMD_SUB  = 5'd3,
		CMD_INC  = 5'd4,
		CMD_LDM  = 5'd5,
		CMD_CLB  = 5'd6,
		CMD_CLC  = 5'd7,
		CMD_IAC  = 5'd8,
		CMD_CMC  = 5'd9,
		CMD_CMA  = 5'd10,
		CMD_RAL  = 5'd11,
		CMD_RAR  = 5'd12,
		CMD_TCC  = 5'd13,
		CMD_DAC  = 5'd14,
		CMD_TCS  = 5'd15,
		CMD_STC  = 5'd16,
		CMD_DAA  = 5'd17,
		CMD_KBP  = 5'd18,
		CMD_ADM  = 5'd19,
		CMD_SBM  = 5'd20,
		CMD_LDX  = 5'd21,
		CMD_DCL  = 5'd22
	} cmd_t;

	// Accumulator, carry and bank select: the state kept outside the register file
	typedef struct packed {
		logic [NIB_W-1:0]  acc;
		logic              carry;
		logic [BANK_W-1:0] bank;
	} arch_t;

	localparam logic [NIB_W-1:0] DAA_ADJ  = 4'd6;
	localparam logic [NIB_W-1:0] DAA_MAX  = 4'd9;
	localparam logic [NIB_W-1:0] TCS_SET  = 4'd10;
	localparam logic [NIB_W-1:0] TCS_CLR  = 4'd9;
	localparam logic [NIB_W-1:0] KBP_ERR  = 4'd15;

endpackage : nacc_pkg

`default_nettype wire

// File: rtl/core/nacc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module nacc_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : nacc_ram

`default_nettype wire

// File: rtl/core/nacc_alu.sv
// Nibble ALU: computes the next accumulator, carry, bank and working register
// for one operation. Depends on nacc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nacc_alu (
	input  wire logic [nacc_pkg::CMD_W-1:0] cmd,
	input  wire nacc_pkg::arch_t            cur,
	input  wire logic [nacc_pkg::NIB_W-1:0] reg_val,
	input  wire logic [nacc_pkg::NIB_W-1:0] immediate,
	input  wire logic [nacc_pkg::NIB_W-1:0] ext_nibble,
	output      nacc_pkg::arch_t            nxt,
	output      logic [nacc_pkg::NIB_W-1:0] reg_new
);
	import nacc_pkg::*;

	logic [NIB_W-1:0] add_b;
	logic             add_cin;
	logic [NIB_W:0]   add_sum;
	logic [NIB_W:0]   daa_sum;

	// Shared adder operand select; subtracts take one's complements
	always_comb begin
		unique case (cmd)
			CMD_ADD: begin add_b = reg_val;     add_cin = cur.carry;  end
			CMD_SUB: begin add_b = ~reg_val;    add_cin = ~cur.carry; end
			CMD_ADM: begin add_b = ext_nibble;  add_cin = cur.carry;  end
			CMD_SBM: begin add_b = ~ext_nibble; add_cin = ~cur.carry; end
			CMD_IAC: begin add_b = 4'd1;        add_cin = 1'b0;       end
			default: begin add_b = '0;          add_cin = 1'b0;       end
		endcase
	end

	assign add_sum = {1'b0, cur.acc} + {1'b0, add_b} + {{NIB_W{1'b0}}, add_cin};
	assign daa_sum = {1'b0, cur.acc} + {1'b0, DAA_ADJ};

	always_comb begin
		nxt     = cur;
		reg_new = reg_val;
		unique case (cmd)
			CMD_LD:  nxt.acc = reg_val;
			CMD_XCH: begin
				nxt.acc = reg_val;
				reg_new = cur.acc;
			end
			CMD_ADD, CMD_SUB, CMD_ADM, CMD_SBM, CMD_IAC: begin
				nxt.acc   = add_sum[NIB_W-1:0];
				nxt.carry = add_sum[NIB_W];
			end
			CMD_INC: reg_new = reg_val + 4'd1;
			CMD_LDM: nxt.acc = immediate;
			CMD_CLB: begin
				nxt.acc   = '0;
				nxt.carry = 1'b0;
			end
			CMD_CLC: nxt.carry = 1'b0;
			CMD_CMC: nxt.carry = ~cur.carry;
			CMD_CMA: nxt.acc = ~cur.acc;
			CMD_RAL: begin
				nxt.carry = cur.acc[NIB_W-1];
				nxt.acc   = {cur.acc[NIB_W-2:0], cur.carry};
			end
			CMD_RAR: begin
				nxt.carry = cur.acc[0];
				nxt.acc   = {cur.carry, cur.acc[NIB_W-1:1]};
			end
			CMD_TCC: begin
				nxt.acc   = {{(NIB_W-1){1'b0}}, cur.carry};
				nxt.carry = 1'b0;
			end
			CMD_DAC: begin
				nxt.carry = (cur.acc != '0);
				nxt.acc   = cur.acc - 4'd1;
			end
			CMD_TCS: begin
				nxt.acc   = cur.carry ? TCS_SET : TCS_CLR;
				nxt.carry = 1'b0;
			end
			CMD_STC: nxt.carry = 1'b1;
			CMD_DAA: begin
				if ((cur.acc > DAA_MAX) || cur.carry) begin
					nxt.acc   = daa_sum[NIB_W-1:0];
					nxt.carry = cur.carry | daa_sum[NIB_W];
				end
			end
			CMD_KBP: begin
				unique case (cur.acc)
					4'd0, 4'd1, 4'd2: nxt.acc = cur.acc;
					4'd4:             nxt.acc = 4'd3;
					4'd8:             nxt.acc = 4'd4;
					default:          nxt.acc = KBP_ERR;
				endcase
			end
			CMD_LDX: nxt.acc = ext_nibble;
			CMD_DCL: nxt.bank = cur.acc[BANK_W-1:0];
			default: ; // unused codes leave the state as it is
		endcase
	end

endmodule : nacc_alu

`default_nettype wire

// File: rtl/core/nibble_accumulator_alu_core.sv
// Top level of the nibble accumulator ALU core.
// Depends on nacc_pkg, nacc_ram and nacc_alu.
`timescale 1ns / 1ps
`default_nettype none

// One instruction per cycle sustained while the output is not stalled; the
// registered read of the working register RAM is taken at the input transfer,
// and the instruction then executes and registers its result when it retires.
// The sixteen working registers live in a 16x4 RAM read at transfer time and
// written back when the instruction retires; a one-entry write-back bypass
// covers back-to-back use of the same register, and per-entry valid bits make
// every register read as zero after reset without a clearing pass. A result
// held by a stalled output blocks the next retire, which stalls the input.
// Accumulator, carry and bank select are flip-flops and are shown directly
// on the result ports.
module nibble_accumulator_alu_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic [nacc_pkg::CMD_W-1:0]    cmd,
	input  wire logic [nacc_pkg::RIDX_W-1:0]   reg_index,
	input  wire logic [nacc_pkg::NIB_W-1:0]    immediate,
	input  wire logic [nacc_pkg::NIB_W-1:0]    ext_nibble,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic [nacc_pkg::NIB_W-1:0]    acc_out,
	output      logic                          carry_out,
	output      logic [nacc_pkg::NIB_W-1:0]    reg_out,
	output      logic [nacc_pkg::BANK_W-1:0]   bank_out
);
	import nacc_pkg::*;

	logic              in_xfer;
	logic              retire;

	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [RIDX_W-1:0] idx_s1;
	logic [NIB_W-1:0]  imm_s1;
	logic [NIB_W-1:0]  ext_s1;

	arch_t             arch_q;
	arch_t             arch_nxt;
	logic              out_valid_q;
	logic [NIB_W-1:0]  reg_out_q;

	logic [NREGS-1:0]  vld_q;
	logic              byp_valid_q;
	logic [RIDX_W-1:0] byp_addr_q;
	logic [NIB_W-1:0]  byp_data_q;

	logic [NIB_W-1:0]  ram_rdata;
	logic [NIB_W-1:0]  reg_rd;
	logic [NIB_W-1:0]  reg_new;

	assign retire   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || retire;
	assign in_xfer  = in_valid && in_ready;

	nacc_ram #(
		.WIDTH (NIB_W),
		.DEPTH (NREGS)
	) u_regfile (
		.clk   (clk),
		.we    (retire),
		.waddr (idx_s1),
		.wdata (reg_new),
		.re    (in_xfer),
		.raddr (reg_index),
		.rdata (ram_rdata)
	);

	// Prefer the last write-back; unwritten entries read as zero
	always_comb begin
		priority if (byp_valid_q && (byp_addr_q == idx_s1)) begin
			reg_rd = byp_data_q;
		end else if (vld_q[idx_s1]) begin
			reg_rd = ram_rdata;
		end else begin
			reg_rd = '0;
		end
	end

	nacc_alu u_alu (
		.cmd        (cmd_s1),
		.cur        (arch_q),
		.reg_val    (reg_rd),
		.immediate  (imm_s1),
		.ext_nibble (ext_s1),
		.nxt        (arch_nxt),
		.reg_new    (reg_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			arch_q      <= '0;
			vld_q       <= '0;
			byp_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (retire) begin
				valid_s1 <= 1'b0;
			end
			if (retire) begin
				out_valid_q   <= 1'b1;
				arch_q        <= arch_nxt;
				vld_q[idx_s1] <= 1'b1;
				byp_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1 <= cmd;
			idx_s1 <= reg_index;
			imm_s1 <= immediate;
			ext_s1 <= ext_nibble;
		end
		if (retire) begin
			reg_out_q  <= reg_new;
			byp_addr_q <= idx_s1;
			byp_data_q <= reg_new;
		end
	end

	assign out_valid = out_valid_q;
	assign acc_out   = arch_q.acc;
	assign carry_out = arch_q.carry;
	assign bank_out  = arch_q.bank;
	assign reg_out   = reg_out_q;

	// Architectural state moves only when an instruction retires
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!retire |=> $stable(arch_q))
		else $error("accumulator state changed without a retiring instruction");

	// Only exchange and increment alter the selected register
	a_reg_untouched: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (cmd_s1 != CMD_XCH) && (cmd_s1 != CMD_INC)) |-> (reg_new == reg_rd))
		else $error("working register modified by a non-writing operation");

	// Bypass tracks the register written by the last retiring instruction
	a_bypass_addr: assert property (@(posedge clk) disable iff (!arst_n)
		retire |=> (byp_valid_q && (byp_addr_q == $past(idx_s1)) && vld_q[byp_addr_q]))
		else $error("write-back bypass lost track of the last write");

endmodule : nibble_accumulator_alu_core

`default_nettype wire

// File: tb/tb_nibble_accumulator_alu_core.sv
// Self-checking testbench for nibble_accumulator_alu_core.
// A directed run and a random run are compared against an in-bench model;
// depends on nacc_pkg and the core.
`timescale 1ns / 1ps

module tb_nibble_accumulator_alu_core;
	import nacc_pkg::*;

	localparam int unsigned FIRST_SPARE    = int'(CMD_DCL) + 1;
	localparam int unsigned LAST_SPARE     = (1 << CMD_W) - 1;
	localparam int unsigned RANDOM_ITEMS   = 740;
	localparam int unsigned TAIL_ITEMS     = 100;
	localparam int unsigned DRAIN_CYCLES   = 10;
	localparam int unsigned WATCHDOG_LIMIT = 1000;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [RIDX_W-1:0] ridx;
		logic [NIB_W-1:0]  imm;
		logic [NIB_W-1:0]  ext;
	} instr_t;

	typedef struct {
		logic [NIB_W-1:0]  acc;
		logic              carry;
		logic [NIB_W-1:0]  regv;
		logic [BANK_W-1:0] bank;
	} state_view_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic [CMD_W-1:0]    cmd        = '0;
	logic [RIDX_W-1:0]   reg_index  = '0;
	logic [NIB_W-1:0]    immediate  = '0;
	logic [NIB_W-1:0]    ext_nibble = '0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [NIB_W-1:0]    acc_out;
	logic                carry_out;
	logic [NIB_W-1:0]    reg_out;
	logic [BANK_W-1:0]   bank_out;

	// Model state of the core
	logic [NIB_W-1:0]    mdl_acc;
	logic                mdl_carry;
	logic [NIB_W-1:0]    mdl_regs [NREGS];
	logic [BANK_W-1:0]   mdl_bank;

	instr_t              pending_instrs [$];
	state_view_t         expected_states [$];
	instr_t              drv_instr;
	int unsigned         drv_gap       = 0;
	int unsigned         rdy_gap       = 0;
	int unsigned         total_instrs  = 0;
	int unsigned         accepted      = 0;
	int unsigned         idle_cycles   = 0;
	int unsigned         mismatches    = 0;

	nibble_accumulator_alu_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.reg_index  (reg_index),
		.immediate  (immediate),
		.ext_nibble (ext_nibble),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.acc_out    (acc_out),
		.carry_out  (carry_out),
		.reg_out    (reg_out),
		.bank_out   (bank_out)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Five-bit sum: acc + operand + carry in
	function automatic logic [NIB_W:0] nib_sum(input logic [NIB_W-1:0] a,
			input logic [NIB_W-1:0] b, input logic cin);
		nib_sum = {1'b0, a} + {1'b0, b} + {{NIB_W{1'b0}}, cin};
	endfunction

	// Apply one instruction to the model state and return the visible state
	function automatic state_view_t execute_instr(input instr_t it);
		logic [NIB_W:0]   s;
		logic [NIB_W-1:0] t;
		logic             c;
		state_view_t      v;
		case (cmd_t'(it.cmd))
			CMD_LD:  mdl_acc = mdl_regs[it.ridx];
			CMD_XCH: begin
				t = mdl_acc;
				mdl_acc = mdl_regs[it.ridx];
				mdl_regs[it.ridx] = t;
			end
			CMD_ADD: {mdl_carry, mdl_acc} = nib_sum(mdl_acc, mdl_regs[it.ridx], mdl_carry);
			CMD_SUB: {mdl_carry, mdl_acc} = nib_sum(mdl_acc, ~mdl_regs[it.ridx], ~mdl_carry);
			CMD_INC: mdl_regs[it.ridx] = mdl_regs[it.ridx] + 1'b1;
			CMD_LDM: mdl_acc = it.imm;
			CMD_CLB: begin
				mdl_acc = '0;
				mdl_carry = 1'b0;
			end
			CMD_CLC: mdl_carry = 1'b0;
			CMD_IAC: {mdl_carry, mdl_acc} = nib_sum(mdl_acc, '0, 1'b1);
			CMD_CMC: mdl_carry = ~mdl_carry;
			CMD_CMA: mdl_acc = ~mdl_acc;
			CMD_RAL: begin
				c = mdl_carry;
				mdl_carry = mdl_acc[NIB_W-1];
				mdl_acc = {mdl_acc[NIB_W-2:0], c};
			end
			CMD_RAR: begin
				c = mdl_carry;
				mdl_carry = mdl_acc[0];
				mdl_acc = {c, mdl_acc[NIB_W-1:1]};
			end
			CMD_TCC: begin
				mdl_acc = {{(NIB_W-1){1'b0}}, mdl_carry};
				mdl_carry = 1'b0;
			end
			CMD_DAC: begin
				mdl_carry = (mdl_acc != '0);
				mdl_acc = mdl_acc - 1'b1;
			end
			CMD_TCS: begin
				mdl_acc = mdl_carry ? TCS_SET : TCS_CLR;
				mdl_carry = 1'b0;
			end
			CMD_STC: mdl_carry = 1'b1;
			CMD_DAA: begin
				if (mdl_acc > DAA_MAX || mdl_carry) begin
					s = {1'b0, mdl_acc} + {1'b0, DAA_ADJ};
					if (s[NIB_W])
						mdl_carry = 1'b1;
					mdl_acc = s[NIB_W-1:0];
				end
			end
			CMD_KBP: begin
				case (mdl_acc)
					4'd0, 4'd1, 4'd2: ;
					4'd4: mdl_acc = 4'd3;
					4'd8: mdl_acc = 4'd4;
					default: mdl_acc = KBP_ERR;
				endcase
			end
			CMD_ADM: {mdl_carry, mdl_acc} = nib_sum(mdl_acc, it.ext, mdl_carry);
			CMD_SBM: {mdl_carry, mdl_acc} = nib_sum(mdl_acc, ~it.ext, ~mdl_carry);
			CMD_LDX: mdl_acc = it.ext;
			CMD_DCL: mdl_bank = mdl_acc[BANK_W-1:0];
			default: ;
		endcase
		v.acc   = mdl_acc;
		v.carry = mdl_carry;
		v.regv  = mdl_regs[it.ridx];
		v.bank  = mdl_bank;
		return v;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic add_instr(input logic [CMD_W-1:0] c, input logic [RIDX_W-1:0] r,
			input logic [NIB_W-1:0] i, input logic [NIB_W-1:0] e);
		instr_t it;
		it.cmd  = c;
		it.ridx = r;
		it.imm  = i;
		it.ext  = e;
		pending_instrs.push_back(it);
	endtask

	// Driver: present the next instruction once the previous one has transferred
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_states.push_back(execute_instr(drv_instr));
				accepted++;
			end
			if (!in_valid || in_ready) begin
				if (drv_gap > 0) begin
					drv_gap--;
					in_valid <= 1'b0;
				end else if (pending_instrs.size() > 0) begin
					drv_instr = pending_instrs.pop_front();
					cmd        <= drv_instr.cmd;
					reg_index  <= drv_instr.ridx;
					immediate  <= drv_instr.imm;
					ext_nibble <= drv_instr.ext;
					in_valid   <= 1'b1;
					if (pending_instrs.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
						drv_gap = $urandom_range(1, 10);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer and throttle out_ready in bursts
	always @(posedge clk) begin
		state_view_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_states.size() == 0) begin
					report_mismatch("unexpected result acc", acc_out, 0);
				end else begin
					want = expected_states.pop_front();
					if (acc_out !== want.acc)
						report_mismatch("acc_out", acc_out, want.acc);
					if (carry_out !== want.carry)
						report_mismatch("carry_out", carry_out, want.carry);
					if (reg_out !== want.regv)
						report_mismatch("reg_out", reg_out, want.regv);
					if (bank_out !== want.bank)
						report_mismatch("bank_out", bank_out, want.bank);
				end
			end
			if (rdy_gap > 0) begin
				rdy_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (pending_instrs.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
					rdy_gap = $urandom_range(1, 10);
			end
		end
	end

	// Watchdog: end the run when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("** nibble_accumulator_alu_core: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned c;
		mdl_acc   = '0;
		mdl_carry = 1'b0;
		mdl_bank  = '0;
		for (int k = 0; k < NREGS; k++)
			mdl_regs[k] = '0;

		// Directed: field extremes, every operation, an unused code
		add_instr(CMD_LDM, 4'd0,  4'd15, 4'd0);
		add_instr(CMD_XCH, 4'd15, 4'd0,  4'd15);
		add_instr(CMD_LD,  4'd15, 4'd15, 4'd0);
		add_instr(CMD_ADD, 4'd15, 4'd0,  4'd15);
		add_instr(CMD_SUB, 4'd0,  4'd15, 4'd0);
		add_instr(CMD_INC, 4'd0,  4'd0,  4'd15);
		add_instr(CMD_INC, 4'd0,  4'd0,  4'd0);
		add_instr(CMD_CLB, 4'd15, 4'd15, 4'd15);
		add_instr(CMD_STC, 4'd0,  4'd0,  4'd0);
		add_instr(CMD_CLC, 4'd15, 4'd0,  4'd0);
		add_instr(CMD_IAC, 4'd0,  4'd0,  4'd0);
		add_instr(CMD_CMC, 4'd0,  4'd0,  4'd0);
		add_instr(CMD_CMA, 4'd0,  4'd0,  4'd0);
		add_instr(CMD_RAL, 4'd0,  4'd0,  4'd0);
		add_instr(CMD_RAR, 4'd0,  4'd0,  4'd0);
		add_instr(CMD_TCC, 4'd0,  4'd0,  4'd0);
		add_instr(CMD_DAC, 4'd0,  4'd0,  4'd0);
		add_instr(CMD_DAC, 4'd0,  4'd0,  4'd0);
		add_instr(CMD_TCS, 4'd0,  4'd0,  4'd0);
		add_instr(CMD_DAA, 4'd0,  4'd0,  4'd0);
		add_instr(CMD_KBP, 4'd0,  4'd0,  4'd0);
		add_instr(CMD_ADM, 4'd0,  4'd0,  4'd15);
		add_instr(CMD_SBM, 4'd0,  4'd0,  4'd0);
		add_instr(CMD_LDX, 4'd0,  4'd0,  4'd15);
		add_instr(CMD_DCL, 4'd15, 4'd0,  4'd0);
		add_instr(CMD_W'(LAST_SPARE), 4'd15, 4'd15, 4'd15);

		// Random: mostly defined codes, a narrow register window for half of the
		// items on average to hit back-to-back use of one register
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 9) == 0)
				c = $urandom_range(FIRST_SPARE, LAST_SPARE);
			else
				c = $urandom_range(0, int'(CMD_DCL));
			add_instr(CMD_W'(c),
				RIDX_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15)),
				NIB_W'($urandom_range(0, 15)), NIB_W'($urandom_range(0, 15)));
		end
		total_instrs = pending_instrs.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted < total_instrs)
			@(posedge clk);
		while (expected_states.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_states.size() != 0)
			report_mismatch("results left over", expected_states.size(), 0);

		if (mismatches == 0)
			$display("** nibble_accumulator_alu_core: PASSED **");
		else
			$display("** nibble_accumulator_alu_core: FAILED **");
		$finish;
	end

endmodule
